### rtl/fntc_pkg.sv
// Types, codes and constants shared by the synthesizer tuning controller.
`default_nettype none

package fntc_pkg;

  localparam int unsigned FREQ_W  = 33;
  localparam int unsigned REF_W   = 28;
  localparam int unsigned STEP_W  = 24;
  localparam int unsigned PWR_W   = 8;
  localparam int unsigned OP_W    = 4;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned CFG_W   = 33;
  localparam int unsigned CIDX_W  = 2;

  // Serial divider widths: dividend shift register, remainder, step count.
  localparam int unsigned DVD_W   = 33;
  localparam int unsigned REM_W   = 29;
  localparam int unsigned CNT_W   = 6;
  localparam int unsigned PROD_W  = 40;
  localparam int unsigned NUM_W   = 41;
  localparam int unsigned FQ_BITS = 13;

  localparam logic [CNT_W-1:0] INT_STEPS  = CNT_W'(DVD_W);
  localparam logic [CNT_W-1:0] FRAC_STEPS = CNT_W'(FQ_BITS);

  localparam logic [11:0] FRAC_MODULUS = 12'd4095;

  localparam logic [FREQ_W-1:0] PRESCALE_HZ = 33'd3600000000;

  localparam logic [REF_W-1:0]  REF_RST  = 28'd25000000;
  localparam logic [FREQ_W-1:0] FMIN_RST = 33'd35000000;
  localparam logic [FREQ_W-1:0] FMAX_RST = 33'd4400000000;
  localparam logic [FREQ_W-1:0] FREQ_RST = 33'd1000000000;
  localparam logic [1:0]        PWR_RST  = 2'd3;
  localparam logic [STEP_W-1:0] STEP_RST = 24'd1000;

  // Fixed register words.
  localparam logic [WORD_W-1:0] W2_CONST = (32'd6 << 26) | (32'd1 << 14) | (32'd7 << 9) |
                                           (32'd1 << 8) | (32'd1 << 6) | 32'd2;
  localparam logic [WORD_W-1:0] W3_CONST = (32'd150 << 3) | 32'd3;
  localparam logic [WORD_W-1:0] W5_CONST = (32'd1 << 22) | (32'd3 << 19) | 32'd5;

  typedef enum logic [OP_W-1:0] {
    OP_SET_FREQ  = 4'd0,
    OP_SET_POWER = 4'd1,
    OP_ENABLE    = 4'd2,
    OP_DISABLE   = 4'd3,
    OP_TOGGLE    = 4'd4,
    OP_SET_STEP  = 4'd5,
    OP_STEP_UP   = 4'd6,
    OP_STEP_DOWN = 4'd7,
    OP_STATUS    = 4'd8
  } op_e;

  typedef enum logic [CIDX_W-1:0] {
    CFG_REF_CLOCK = 2'd0,
    CFG_MIN_FREQ  = 2'd1,
    CFG_MAX_FREQ  = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SETUP,
    ST_VCO,
    ST_DIV_INT,
    ST_MUL,
    ST_FSTART,
    ST_DIV_FRAC,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [FREQ_W-1:0] freq_value;
    logic [PWR_W-1:0]  power_value;
    logic [STEP_W-1:0] step_value;
  } cmd_t;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] steps;
  } div_req_t;

  function automatic logic [2:0] pick_div(input logic [FREQ_W-1:0] f);
    logic [2:0] d;
    d = 3'd6;
    priority if (f >= 33'd2200000000) d = 3'd0;
    else if (f >= 33'd1100000000)     d = 3'd1;
    else if (f >= 33'd550000000)      d = 3'd2;
    else if (f >= 33'd275000000)      d = 3'd3;
    else if (f >= 33'd137500000)      d = 3'd4;
    else if (f >= 33'd68750000)       d = 3'd5;
    else                              d = 3'd6;
    return d;
  endfunction

  function automatic logic is_decade(input logic [STEP_W-1:0] s);
    return (s == 24'd10) || (s == 24'd100) || (s == 24'd1000) || (s == 24'd10000) ||
           (s == 24'd100000) || (s == 24'd1000000) || (s == 24'd10000000);
  endfunction

endpackage

`default_nettype wire

### rtl/fntc_if.sv
// Command and result channel interfaces of the synthesizer tuning controller.
`default_nettype none

interface fntc_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [fntc_pkg::OP_W-1:0]    op;
  logic [fntc_pkg::FREQ_W-1:0]  freq_value;
  logic [fntc_pkg::PWR_W-1:0]   power_value;
  logic [fntc_pkg::STEP_W-1:0]  step_value;

  modport source (output valid, op, freq_value, power_value, step_value, input ready);
  modport sink   (input valid, op, freq_value, power_value, step_value, output ready);
endinterface

interface fntc_res_if;
  logic                         valid;
  logic                         ready;
  logic [fntc_pkg::WORD_W-1:0]  reg_word;
  logic [2:0]                   reg_index;
  logic                         word_valid;
  logic                         last;
  logic [fntc_pkg::FREQ_W-1:0]  cur_frequency_hz;
  logic [1:0]                   cur_power;
  logic                         cur_rf_on;
  logic [fntc_pkg::STEP_W-1:0]  cur_step_hz;

  modport source (output valid, reg_word, reg_index, word_valid, last, cur_frequency_hz,
                  cur_power, cur_rf_on, cur_step_hz, input ready);
  modport sink   (input valid, reg_word, reg_index, word_valid, last, cur_frequency_hz,
                  cur_power, cur_rf_on, cur_step_hz, output ready);
endinterface

`default_nettype wire

### rtl/frac_n_synth_tuning_control_top.sv
// Top level of the fractional-N synthesizer tuning controller.
// A command that retunes gives six register words, R5 first and R0 last, each held until
// the result side takes it; any other command gives a single status beat. A new command
// is taken only with the block idle, after the last beat of the one before has gone out.
// INT and FRAC both come from the shared bit-serial divider.
// Reset (asynchronous, active low) restores the settings and tuning state to their defaults.
`default_nettype none

module frac_n_synth_tuning_control_top (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [fntc_pkg::CIDX_W-1:0]     cfg_idx_i,
  input  wire logic [fntc_pkg::CFG_W-1:0]      cfg_data_i,
  fntc_cmd_if.sink                             cmd_i,
  fntc_res_if.source                           res_o
);

  // Sequencer state and latched command.
  fntc_pkg::state_e state_q, state_d;
  fntc_pkg::cmd_t   cmd_q;

  // Configuration registers.
  logic [fntc_pkg::REF_W-1:0]  ref_q;
  logic [fntc_pkg::FREQ_W-1:0] fmin_q;
  logic [fntc_pkg::FREQ_W-1:0] fmax_q;

  // Tuning state.
  logic [fntc_pkg::FREQ_W-1:0] freq_q, freq_d;
  logic [1:0]                  pwr_q, pwr_d;
  logic                        rf_q, rf_d;
  logic [fntc_pkg::STEP_W-1:0] step_q, step_d;

  // Word build results.
  logic [2:0]                  div_q;
  logic                        pre_q;
  logic [16:0]                 int_q;
  logic [fntc_pkg::PROD_W-1:0] prod_q;
  logic [11:0]                 frac_q;

  // Emission control: index of the word on the port, and status-only flag.
  logic [2:0] widx_q, widx_d;
  logic       stat_q, stat_d;

  logic                        cmd_acc;
  logic                        upd;
  logic [fntc_pkg::FREQ_W:0]   f_up;
  logic [fntc_pkg::FREQ_W:0]   f_dn;
  logic                        up_ok;
  logic                        dn_ok;
  logic                        fset_ok;
  logic [fntc_pkg::REF_W-1:0]  ref_eff;
  logic [fntc_pkg::FREQ_W-1:0] vco;
  logic [fntc_pkg::NUM_W-1:0]  fnum;

  fntc_pkg::div_req_t          div_req;
  logic [fntc_pkg::REM_W-1:0]  div_rem_init;
  logic [fntc_pkg::DVD_W-1:0]  div_dvd;
  logic [fntc_pkg::REM_W-1:0]  div_dvs;
  logic                        div_done;
  logic [fntc_pkg::DVD_W-1:0]  div_quo;
  logic [fntc_pkg::REM_W-1:0]  div_rem;

  logic [fntc_pkg::WORD_W-1:0] w0, w1, w4;

  assign cmd_i.ready = (state_q == fntc_pkg::ST_IDLE);
  assign cmd_acc     = cmd_i.valid & cmd_i.ready;

  // Range checks for the step and set commands.
  assign f_up    = {1'b0, freq_q} + {10'b0, step_q};
  assign f_dn    = {1'b0, freq_q} - {10'b0, step_q};
  assign up_ok   = f_up <= {1'b0, fmax_q};
  assign dn_ok   = ~f_dn[fntc_pkg::FREQ_W] & (f_dn[fntc_pkg::FREQ_W-1:0] >= fmin_q);
  assign fset_ok = (cmd_q.freq_value >= fmin_q) & (cmd_q.freq_value <= fmax_q);

  // A zero reference divides as one.
  assign ref_eff = (ref_q == '0) ? fntc_pkg::REF_W'(1) : ref_q;

  // The divider ladder keeps the VCO below 2^33, so the shift never overflows.
  assign vco = freq_q << div_q;

  // FRAC numerator: 2*rem*modulus + ref, divided by 2*ref.
  assign fnum = {prod_q, 1'b0} + {13'b0, ref_eff};

  // Feed the shared divider: the VCO division first, then the rounding division. The
  // top bits of the FRAC numerator sit below the divisor since FRAC fits in 13 bits.
  always_comb begin
    if (state_q == fntc_pkg::ST_VCO) begin
      div_rem_init = '0;
      div_dvd      = vco;
      div_dvs      = {1'b0, ref_eff};
    end else begin
      div_rem_init = {1'b0, fnum[fntc_pkg::NUM_W-1:fntc_pkg::FQ_BITS]};
      div_dvd      = {fnum[fntc_pkg::FQ_BITS-1:0], 20'b0};
      div_dvs      = {ref_eff, 1'b0};
    end
  end

  fntc_sdiv u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .rem_init_i (div_rem_init),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  // Sequencer: next state, tuning updates and divider requests.
  always_comb begin
    state_d = state_q;
    freq_d  = freq_q;
    pwr_d   = pwr_q;
    rf_d    = rf_q;
    step_d  = step_q;
    widx_d  = widx_q;
    stat_d  = stat_q;
    upd     = 1'b0;
    div_req = '0;
    unique case (state_q)
      fntc_pkg::ST_IDLE: begin
        if (cmd_i.valid) begin
          state_d = fntc_pkg::ST_EXEC;
        end
      end
      fntc_pkg::ST_EXEC: begin
        unique case (fntc_pkg::op_e'(cmd_q.op))
          fntc_pkg::OP_SET_FREQ: begin
            if (fset_ok) begin
              freq_d = cmd_q.freq_value;
              upd    = 1'b1;
            end
          end
          fntc_pkg::OP_SET_POWER: begin
            if (cmd_q.power_value <= fntc_pkg::PWR_W'(3)) begin
              pwr_d = cmd_q.power_value[1:0];
              upd   = 1'b1;
            end
          end
          fntc_pkg::OP_ENABLE: begin
            rf_d = 1'b1;
            upd  = 1'b1;
          end
          fntc_pkg::OP_DISABLE: begin
            rf_d = 1'b0;
            upd  = 1'b1;
          end
          fntc_pkg::OP_TOGGLE: begin
            rf_d = ~rf_q;
            upd  = 1'b1;
          end
          fntc_pkg::OP_SET_STEP: begin
            // A new step never reaches the synthesizer on its own.
            if (fntc_pkg::is_decade(cmd_q.step_value)) begin
              step_d = cmd_q.step_value;
            end
          end
          fntc_pkg::OP_STEP_UP: begin
            if (up_ok) begin
              freq_d = f_up[fntc_pkg::FREQ_W-1:0];
              upd    = 1'b1;
            end
          end
          fntc_pkg::OP_STEP_DOWN: begin
            // Underflow counts as a rejected step.
            if (dn_ok) begin
              freq_d = f_dn[fntc_pkg::FREQ_W-1:0];
              upd    = 1'b1;
            end
          end
          default: begin
            // Status and unknown codes change nothing.
          end
        endcase
        if (upd) begin
          state_d = fntc_pkg::ST_SETUP;
        end else begin
          stat_d  = 1'b1;
          widx_d  = '0;
          state_d = fntc_pkg::ST_EMIT;
        end
      end
      fntc_pkg::ST_SETUP: begin
        state_d = fntc_pkg::ST_VCO;
      end
      fntc_pkg::ST_VCO: begin
        div_req.start = 1'b1;
        div_req.steps = fntc_pkg::INT_STEPS;
        state_d       = fntc_pkg::ST_DIV_INT;
      end
      fntc_pkg::ST_DIV_INT: begin
        if (div_done) begin
          state_d = fntc_pkg::ST_MUL;
        end
      end
      fntc_pkg::ST_MUL: begin
        state_d = fntc_pkg::ST_FSTART;
      end
      fntc_pkg::ST_FSTART: begin
        div_req.start = 1'b1;
        div_req.steps = fntc_pkg::FRAC_STEPS;
        state_d       = fntc_pkg::ST_DIV_FRAC;
      end
      fntc_pkg::ST_DIV_FRAC: begin
        if (div_done) begin
          stat_d  = 1'b0;
          widx_d  = 3'd5;
          state_d = fntc_pkg::ST_EMIT;
        end
      end
      fntc_pkg::ST_EMIT: begin
        // Advance on each beat taken; drop back to idle after the last one.
        if (res_o.ready) begin
          if (stat_q || (widx_q == 3'd0)) begin
            state_d = fntc_pkg::ST_IDLE;
          end else begin
            widx_d = widx_q - 3'd1;
          end
        end
      end
      default: begin
        state_d = fntc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fntc_pkg::ST_IDLE;
      ref_q   <= fntc_pkg::REF_RST;
      fmin_q  <= fntc_pkg::FMIN_RST;
      fmax_q  <= fntc_pkg::FMAX_RST;
      freq_q  <= fntc_pkg::FREQ_RST;
      pwr_q   <= fntc_pkg::PWR_RST;
      rf_q    <= 1'b0;
      step_q  <= fntc_pkg::STEP_RST;
      widx_q  <= '0;
      stat_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      freq_q  <= freq_d;
      pwr_q   <= pwr_d;
      rf_q    <= rf_d;
      step_q  <= step_d;
      widx_q  <= widx_d;
      stat_q  <= stat_d;
      if (cfg_we_i) begin
        unique case (fntc_pkg::cfg_idx_e'(cfg_idx_i))
          fntc_pkg::CFG_REF_CLOCK: ref_q  <= cfg_data_i[fntc_pkg::REF_W-1:0];
          fntc_pkg::CFG_MIN_FREQ:  fmin_q <= cfg_data_i;
          fntc_pkg::CFG_MAX_FREQ:  fmax_q <= cfg_data_i;
          default: begin
            // No register at this index: drop the write.
          end
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_acc) begin
      cmd_q.op          <= cmd_i.op;
      cmd_q.freq_value  <= cmd_i.freq_value;
      cmd_q.power_value <= cmd_i.power_value;
      cmd_q.step_value  <= cmd_i.step_value;
    end
    if (state_q == fntc_pkg::ST_SETUP) begin
      div_q <= fntc_pkg::pick_div(freq_q);
    end
    if (state_q == fntc_pkg::ST_VCO) begin
      pre_q <= (vco >= fntc_pkg::PRESCALE_HZ);
    end
    if ((state_q == fntc_pkg::ST_DIV_INT) && div_done) begin
      int_q <= div_quo[16:0];
    end
    if (state_q == fntc_pkg::ST_MUL) begin
      // The remainder is below the reference, so 28 bits hold it.
      prod_q <= {12'b0, div_rem[fntc_pkg::REF_W-1:0]} * {28'b0, fntc_pkg::FRAC_MODULUS};
    end
    if ((state_q == fntc_pkg::ST_DIV_FRAC) && div_done) begin
      frac_q <= div_quo[11:0];
    end
  end

  // Register words that depend on the tuning.
  assign w0 = {int_q, frac_q, 3'b000};
  assign w1 = {4'b0, pre_q, 11'b0, 1'b1, fntc_pkg::FRAC_MODULUS, 3'b001};
  assign w4 = {8'b0, 1'b1, div_q, 8'd250, 1'b0, 1'b1, 4'b0, rf_q, pwr_q, 3'b100};

  always_comb begin
    res_o.reg_word = '0;
    if (!stat_q) begin
      unique case (widx_q)
        3'd0:    res_o.reg_word = w0;
        3'd1:    res_o.reg_word = w1;
        3'd2:    res_o.reg_word = fntc_pkg::W2_CONST;
        3'd3:    res_o.reg_word = fntc_pkg::W3_CONST;
        3'd4:    res_o.reg_word = w4;
        3'd5:    res_o.reg_word = fntc_pkg::W5_CONST;
        default: res_o.reg_word = '0;
      endcase
    end
  end

  assign res_o.valid            = (state_q == fntc_pkg::ST_EMIT);
  assign res_o.reg_index        = stat_q ? 3'd0 : widx_q;
  assign res_o.word_valid       = ~stat_q;
  assign res_o.last             = stat_q | (widx_q == 3'd0);
  assign res_o.cur_frequency_hz = freq_q;
  assign res_o.cur_power        = pwr_q;
  assign res_o.cur_rf_on        = rf_q;
  assign res_o.cur_step_hz      = step_q;

endmodule

`default_nettype wire

### rtl/fntc_sdiv.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none

module fntc_sdiv (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire fntc_pkg::div_req_t            req_i,
  input  wire logic [fntc_pkg::REM_W-1:0]    rem_init_i,
  input  wire logic [fntc_pkg::DVD_W-1:0]    dividend_i,
  input  wire logic [fntc_pkg::REM_W-1:0]    divisor_i,
  output logic                               done_o,
  output logic [fntc_pkg::DVD_W-1:0]         quo_o,
  output logic [fntc_pkg::REM_W-1:0]         rem_o
);

  logic [fntc_pkg::REM_W-1:0] rem_q, rem_d;
  logic [fntc_pkg::DVD_W-1:0] sh_q, sh_d;
  logic [fntc_pkg::REM_W-1:0] dvs_q;
  logic [fntc_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                       busy_q, busy_d;
  logic                       done_q, done_d;

  logic [fntc_pkg::REM_W:0]   trial;
  logic [fntc_pkg::REM_W+1:0] diff;
  logic                       ge;

  // Bring down the next dividend bit and try the subtraction.
  assign trial = {rem_q, sh_q[fntc_pkg::DVD_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, dvs_q};
  assign ge    = ~diff[fntc_pkg::REM_W+1];

  always_comb begin
    rem_d  = rem_q;
    sh_d   = sh_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = rem_init_i;
      sh_d   = dividend_i;
      cnt_d  = req_i.steps;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[fntc_pkg::REM_W-1:0] : trial[fntc_pkg::REM_W-1:0];
      sh_d  = {sh_q[fntc_pkg::DVD_W-2:0], ge};
      cnt_d = cnt_q - fntc_pkg::CNT_W'(1);
      if (cnt_q == fntc_pkg::CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q  <= sh_d;
    if (req_i.start) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o = done_q;
  assign quo_o  = sh_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

### sim/fntc_tuning_checker.sv
// Checker for the synthesizer tuning controller: predicts the result beats of each command.
`timescale 1ns / 100ps

module fntc_tuning_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [fntc_pkg::CIDX_W-1:0] cfg_idx_i,
  input  logic [fntc_pkg::CFG_W-1:0]  cfg_data_i,
  fntc_cmd_if                         cmd_i,
  fntc_res_if                         res_i,
  output int                          pending_o,
  output int                          fail_count_o
);

  localparam logic [11:0] MODULUS      = 12'd4095;
  localparam logic [63:0] PRESCALER_HZ = 64'd3600000000;
  localparam logic [63:0] TOP_BAND_HZ  = 64'd2200000000;

  typedef struct packed {
    logic [fntc_pkg::WORD_W-1:0] reg_word;
    logic [2:0]                  reg_index;
    logic                        word_valid;
    logic                        last;
    logic [fntc_pkg::FREQ_W-1:0] freq_hz;
    logic [1:0]                  power;
    logic                        rf_on;
    logic [fntc_pkg::STEP_W-1:0] step_hz;
  } tune_beat_t;

  tune_beat_t due_beats_q[$];
  tune_beat_t head;

  // Shadow of the block's settings and tuning state
  logic [fntc_pkg::REF_W-1:0]  ref_hz;
  logic [fntc_pkg::FREQ_W-1:0] lo_hz;
  logic [fntc_pkg::FREQ_W-1:0] hi_hz;
  logic [fntc_pkg::FREQ_W-1:0] freq_hz;
  logic [1:0]                  power;
  logic                        rf_on;
  logic [fntc_pkg::STEP_W-1:0] step_hz;

  // Output divider: each band halves the one above, down to 68.75 MHz.
  function automatic logic [2:0] out_divider(input logic [fntc_pkg::FREQ_W-1:0] f);
    logic [2:0] d;
    d = 3'd6;
    for (int k = 5; k >= 0; k--) begin
      if (64'(f) >= (TOP_BAND_HZ >> k)) d = 3'(k);
    end
    return d;
  endfunction

  function automatic logic decade_step(input logic [fntc_pkg::STEP_W-1:0] s);
    logic [31:0] d;
    logic        hit;
    d   = 32'd10;
    hit = 1'b0;
    repeat (7) begin
      hit |= (32'(s) == d);
      d = d * 32'd10;
    end
    return hit;
  endfunction

  // Register words R0..R5 for the present tuning state.
  function automatic logic [5:0][fntc_pkg::WORD_W-1:0] synth_words(
      input logic [fntc_pkg::FREQ_W-1:0] f,
      input logic [fntc_pkg::REF_W-1:0]  refclk,
      input logic                        on,
      input logic [1:0]                  pwr);
    logic [2:0]                       div;
    logic [63:0]                      vco;
    logic [63:0]                      rdiv;
    logic [63:0]                      n_int;
    logic [63:0]                      n_rem;
    logic [63:0]                      n_frac;
    logic                             pre;
    logic [5:0][fntc_pkg::WORD_W-1:0] w;
    div    = out_divider(f);
    vco    = 64'(f) << div;
    rdiv   = (refclk == '0) ? 64'd1 : 64'(refclk);
    n_int  = vco / rdiv;
    n_rem  = vco % rdiv;
    n_frac = (64'd2 * n_rem * 64'(MODULUS) + rdiv) / (64'd2 * rdiv);
    pre    = (vco >= PRESCALER_HZ);
    w[0] = {n_int[16:0], n_frac[11:0], 3'b000};
    w[1] = {4'b0000, pre, 11'b0, 1'b1, MODULUS, 3'b001};
    w[2] = (32'd6 << 26) | (32'd1 << 14) | (32'd7 << 9) | (32'd1 << 8) | (32'd1 << 6) | 32'd2;
    w[3] = (32'd150 << 3) | 32'd3;
    w[4] = (32'd1 << 23) | (32'(div) << 20) | (32'd250 << 12) | (32'd1 << 10) |
           (32'(on) << 5) | (32'(pwr) << 3) | 32'd4;
    w[5] = (32'd1 << 22) | (32'd3 << 19) | 32'd5;
    return w;
  endfunction

  task automatic predict_command(input logic [fntc_pkg::OP_W-1:0]   op,
                                 input logic [fntc_pkg::FREQ_W-1:0] fv,
                                 input logic [fntc_pkg::PWR_W-1:0]  pv,
                                 input logic [fntc_pkg::STEP_W-1:0] sv);
    logic                             retune;
    logic [5:0][fntc_pkg::WORD_W-1:0] w;
    tune_beat_t                       b;
    retune = 1'b0;
    case (op)
      fntc_pkg::OP_SET_FREQ: begin
        if (fv >= lo_hz && fv <= hi_hz) begin
          freq_hz = fv;
          retune  = 1'b1;
        end
      end
      fntc_pkg::OP_SET_POWER: begin
        if (pv <= fntc_pkg::PWR_W'(3)) begin
          power  = pv[1:0];
          retune = 1'b1;
        end
      end
      fntc_pkg::OP_ENABLE: begin
        rf_on  = 1'b1;
        retune = 1'b1;
      end
      fntc_pkg::OP_DISABLE: begin
        rf_on  = 1'b0;
        retune = 1'b1;
      end
      fntc_pkg::OP_TOGGLE: begin
        rf_on  = ~rf_on;
        retune = 1'b1;
      end
      fntc_pkg::OP_SET_STEP: begin
        if (decade_step(sv)) step_hz = sv;
      end
      fntc_pkg::OP_STEP_UP: begin
        if (64'(freq_hz) + 64'(step_hz) <= 64'(hi_hz)) begin
          freq_hz = freq_hz + fntc_pkg::FREQ_W'(step_hz);
          retune  = 1'b1;
        end
      end
      fntc_pkg::OP_STEP_DOWN: begin
        // reject an underflow as well as a drop below the lower limit
        if (fntc_pkg::FREQ_W'(step_hz) <= freq_hz &&
            freq_hz - fntc_pkg::FREQ_W'(step_hz) >= lo_hz) begin
          freq_hz = freq_hz - fntc_pkg::FREQ_W'(step_hz);
          retune  = 1'b1;
        end
      end
      default: ;
    endcase

    b.freq_hz = freq_hz;
    b.power   = power;
    b.rf_on   = rf_on;
    b.step_hz = step_hz;
    if (retune) begin
      w = synth_words(freq_hz, ref_hz, rf_on, power);
      for (int k = 5; k >= 0; k--) begin
        b.reg_word   = w[k];
        b.reg_index  = 3'(k);
        b.word_valid = 1'b1;
        b.last       = (k == 0);
        due_beats_q.push_back(b);
      end
    end else begin
      b.reg_word   = '0;
      b.reg_index  = '0;
      b.word_valid = 1'b0;
      b.last       = 1'b1;
      due_beats_q.push_back(b);
    end
  endtask

  function automatic int field_differs(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
    if (want === got) return 0;
    $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
    return 1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_hz       = 28'd25000000;
      lo_hz        = 33'd35000000;
      hi_hz        = 33'd4400000000;
      freq_hz      = 33'd1000000000;
      power        = 2'd3;
      rf_on        = 1'b0;
      step_hz      = 24'd1000;
      fail_count_o = 0;
      due_beats_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          fntc_pkg::CFG_REF_CLOCK: ref_hz = cfg_data_i[fntc_pkg::REF_W-1:0];
          fntc_pkg::CFG_MIN_FREQ:  lo_hz  = cfg_data_i[fntc_pkg::FREQ_W-1:0];
          fntc_pkg::CFG_MAX_FREQ:  hi_hz  = cfg_data_i[fntc_pkg::FREQ_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.valid && cmd_i.ready) begin
        predict_command(cmd_i.op, cmd_i.freq_value, cmd_i.power_value, cmd_i.step_value);
      end
      if (res_i.valid && res_i.ready) begin
        if (due_beats_q.size() == 0) begin
          $error("result beat with no command outstanding");
          fail_count_o++;
        end else begin
          head = due_beats_q.pop_front();
          fail_count_o += field_differs("reg_word", 64'(head.reg_word), 64'(res_i.reg_word));
          fail_count_o += field_differs("reg_index", 64'(head.reg_index),
                                        64'(res_i.reg_index));
          fail_count_o += field_differs("word_valid", 64'(head.word_valid),
                                        64'(res_i.word_valid));
          fail_count_o += field_differs("last", 64'(head.last), 64'(res_i.last));
          fail_count_o += field_differs("cur_frequency_hz", 64'(head.freq_hz),
                                        64'(res_i.cur_frequency_hz));
          fail_count_o += field_differs("cur_power", 64'(head.power), 64'(res_i.cur_power));
          fail_count_o += field_differs("cur_rf_on", 64'(head.rf_on), 64'(res_i.cur_rf_on));
          fail_count_o += field_differs("cur_step_hz", 64'(head.step_hz),
                                        64'(res_i.cur_step_hz));
        end
      end
      pending_o <= due_beats_q.size();
    end
  end

endmodule

### sim/tb_frac_n_synth_tuning_control_top.sv
// Testbench top for the synthesizer tuning controller: stimulus, settings, idling and verdict.
`timescale 1ns / 100ps

module tb_frac_n_synth_tuning_control_top;

  localparam longint unsigned TOP_HZ = 64'd4400000000;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        cfg_we_i;
  logic [fntc_pkg::CIDX_W-1:0] cfg_idx_i;
  logic [fntc_pkg::CFG_W-1:0]  cfg_data_i;

  fntc_cmd_if cmd_bus ();
  fntc_res_if res_bus ();

  int pending;
  int fail_count;

  // Percentage of cycles in which each side holds off
  int snd_idle_pct = 11;
  int rcv_idle_pct = 54;

  // Limits currently programmed, used to aim frequencies at the accepted range
  longint unsigned lo_hz;
  longint unsigned hi_hz;

  frac_n_synth_tuning_control_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd_bus),
    .res_o      (res_bus)
  );

  fntc_tuning_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .cmd_i        (cmd_bus),
    .res_i        (res_bus),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Guard against a hang: the slowest correct run needs well under a millisecond.
  initial begin
    #5000000;
    $display("tb_frac_n_synth_tuning_control_top failed");
    $finish;
  end

  // Result side: drop ready at random, once per clock edge.
  initial begin
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      res_bus.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  function automatic longint unsigned rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic longint unsigned rand_in(input longint unsigned lo,
                                              input longint unsigned hi);
    if (hi <= lo) return lo;
    return lo + rand64() % (hi - lo + 1);
  endfunction

  function automatic logic [fntc_pkg::STEP_W-1:0] pick_decade();
    logic [fntc_pkg::STEP_W-1:0] d;
    d = fntc_pkg::STEP_W'(10);
    repeat ($urandom_range(6)) d = d * fntc_pkg::STEP_W'(10);
    return d;
  endfunction

  // Mostly frequencies the block will take, with the limits, their neighbours just
  // outside, divider band edges and the odd wild value mixed in.
  function automatic logic [fntc_pkg::FREQ_W-1:0] pick_freq();
    longint unsigned f;
    case ($urandom_range(10))
      0, 1, 2, 3, 4: f = rand_in(lo_hz, hi_hz);
      5:             f = rand_in((hi_hz > 30000000) ? hi_hz - 30000000 : 0, hi_hz);
      6:             f = rand_in(lo_hz, lo_hz + 30000000);
      7:             f = lo_hz - 1;
      8:             f = hi_hz + 1;
      9:             f = (64'd2200000000 >> $urandom_range(5)) - $urandom_range(1);
      default:       f = rand64();
    endcase
    return fntc_pkg::FREQ_W'(f);
  endfunction

  // Present one command beat and hold it until the block takes it. Valid is left
  // high on return so that a back-to-back beat needs no second assignment.
  task automatic send_cmd(input logic [fntc_pkg::OP_W-1:0]   op,
                          input logic [fntc_pkg::FREQ_W-1:0] fv,
                          input logic [fntc_pkg::PWR_W-1:0]  pv,
                          input logic [fntc_pkg::STEP_W-1:0] sv);
    while ($urandom_range(99) < snd_idle_pct) begin
      cmd_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_bus.valid       <= 1'b1;
    cmd_bus.op          <= op;
    cmd_bus.freq_value  <= fv;
    cmd_bus.power_value <= pv;
    cmd_bus.step_value  <= sv;
    do @(posedge clk_i); while (!cmd_bus.ready);
  endtask

  // Hold off the command side until every predicted result beat has come back.
  task automatic wait_idle();
    cmd_bus.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_reg(input fntc_pkg::cfg_idx_e idx, input longint unsigned val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= fntc_pkg::CFG_W'(val);
    @(posedge clk_i);
  endtask

  // Reprogram all three settings, only ever with the block idle.
  task automatic set_limits(input longint unsigned refclk, input longint unsigned lo,
                            input longint unsigned hi);
    wait_idle();
    write_reg(fntc_pkg::CFG_REF_CLOCK, refclk);
    write_reg(fntc_pkg::CFG_MIN_FREQ, lo);
    write_reg(fntc_pkg::CFG_MAX_FREQ, hi);
    cfg_we_i <= 1'b0;
    lo_hz = lo;
    hi_hz = hi;
  endtask

  // Random commands: mostly meaningful values, random content in the fields that
  // the operation ignores, now and then a pause until the block has drained.
  task automatic run_random(input int count);
    logic [fntc_pkg::OP_W-1:0]   op;
    logic [fntc_pkg::FREQ_W-1:0] fv;
    logic [fntc_pkg::PWR_W-1:0]  pv;
    logic [fntc_pkg::STEP_W-1:0] sv;
    int                          pick;
    repeat (count) begin
      if ($urandom_range(99) < 4) wait_idle();
      pick = $urandom_range(99);
      fv   = fntc_pkg::FREQ_W'(rand64());
      pv   = fntc_pkg::PWR_W'($urandom());
      sv   = fntc_pkg::STEP_W'($urandom());
      if (pick < 25) begin
        op = fntc_pkg::OP_SET_FREQ;
        fv = pick_freq();
      end else if (pick < 35) begin
        op = fntc_pkg::OP_SET_POWER;
        if ($urandom_range(9) < 7) pv = fntc_pkg::PWR_W'($urandom_range(3));
      end else if (pick < 42) begin
        op = fntc_pkg::OP_ENABLE;
      end else if (pick < 48) begin
        op = fntc_pkg::OP_DISABLE;
      end else if (pick < 55) begin
        op = fntc_pkg::OP_TOGGLE;
      end else if (pick < 65) begin
        op = fntc_pkg::OP_SET_STEP;
        case ($urandom_range(9))
          0, 1, 2, 3, 4, 5, 6: sv = pick_decade();
          7:                   sv = pick_decade() + fntc_pkg::STEP_W'(1);
          8:                   sv = pick_decade() - fntc_pkg::STEP_W'(1);
          default: ;
        endcase
      end else if (pick < 78) begin
        op = fntc_pkg::OP_STEP_UP;
      end else if (pick < 91) begin
        op = fntc_pkg::OP_STEP_DOWN;
      end else if (pick < 96) begin
        op = fntc_pkg::OP_STATUS;
      end else begin
        // codes past the last operation behave as a status request
        op = fntc_pkg::OP_W'($urandom_range((1 << fntc_pkg::OP_W) - 1,
                                            int'(fntc_pkg::OP_STATUS) + 1));
      end
      send_cmd(op, fv, pv, sv);
    end
  endtask

  initial begin
    longint unsigned r_ref;
    longint unsigned r_lo;
    longint unsigned r_hi;

    rst_ni              <= 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_idx_i           <= fntc_pkg::CFG_REF_CLOCK;
    cfg_data_i          <= '0;
    cmd_bus.valid       <= 1'b0;
    cmd_bus.op          <= fntc_pkg::OP_STATUS;
    cmd_bus.freq_value  <= '0;
    cmd_bus.power_value <= '0;
    cmd_bus.step_value  <= '0;
    lo_hz = 64'd35000000;
    hi_hz = TOP_HZ;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed beats against the settings left by reset
    send_cmd(fntc_pkg::OP_STATUS, '0, '0, '0);
    send_cmd(fntc_pkg::OP_ENABLE, '0, '0, '0);
    send_cmd(fntc_pkg::OP_TOGGLE, '0, '0, '0);
    send_cmd(fntc_pkg::OP_DISABLE, '0, '0, '0);
    send_cmd(fntc_pkg::OP_SET_POWER, '0, fntc_pkg::PWR_W'(0), '0);
    send_cmd(fntc_pkg::OP_SET_POWER, '0, fntc_pkg::PWR_W'(4), '0); // just above the top level
    send_cmd(fntc_pkg::OP_SET_POWER, '0, '1, '0);
    send_cmd(fntc_pkg::OP_SET_POWER, '0, fntc_pkg::PWR_W'(3), '0);
    // lower limit, deepest divider
    send_cmd(fntc_pkg::OP_SET_FREQ, fntc_pkg::FREQ_W'(35000000), '0, '0);
    send_cmd(fntc_pkg::OP_SET_FREQ, fntc_pkg::FREQ_W'(34999999), '0, '0);
    // upper limit, prescaler on
    send_cmd(fntc_pkg::OP_SET_FREQ, fntc_pkg::FREQ_W'(TOP_HZ), '0, '0);
    send_cmd(fntc_pkg::OP_SET_FREQ, '1, '0, '0);
    send_cmd(fntc_pkg::OP_SET_STEP, '0, '0, fntc_pkg::STEP_W'(10000000));
    send_cmd(fntc_pkg::OP_STEP_UP, '0, '0, '0);       // would pass the upper limit
    send_cmd(fntc_pkg::OP_STEP_DOWN, '0, '0, '0);
    send_cmd(fntc_pkg::OP_SET_STEP, '0, '0, fntc_pkg::STEP_W'(12345));
    send_cmd(fntc_pkg::OP_SET_STEP, '0, '0, '1);
    // vco lands on the prescaler edge
    send_cmd(fntc_pkg::OP_SET_FREQ, fntc_pkg::FREQ_W'(1800000000), '0, '0);
    send_cmd(fntc_pkg::OP_SET_FREQ, fntc_pkg::FREQ_W'(1799999999), '0, '0);
    send_cmd(fntc_pkg::OP_SET_FREQ, fntc_pkg::FREQ_W'(35000005), '0, '0);
    send_cmd(fntc_pkg::OP_SET_STEP, '0, '0, fntc_pkg::STEP_W'(10));
    send_cmd(fntc_pkg::OP_STEP_DOWN, '0, '0, '0);     // would fall below the lower limit
    send_cmd(fntc_pkg::OP_W'((1 << fntc_pkg::OP_W) - 1), '0, '0, '0);
    run_random(40);

    // Fastest reference, widest range
    set_limits(64'd250000000, 64'd0, TOP_HZ);
    run_random(50);

    // Swap the idling of the two sides
    snd_idle_pct = 54;
    rcv_idle_pct = 11;

    // Slowest reference: INT overflows its field
    set_limits(64'd1, 64'd0, 64'd100000000);
    send_cmd(fntc_pkg::OP_SET_FREQ, fntc_pkg::FREQ_W'(5), '0, '0);
    send_cmd(fntc_pkg::OP_SET_STEP, '0, '0, fntc_pkg::STEP_W'(10));
    send_cmd(fntc_pkg::OP_STEP_DOWN, '0, '0, '0);     // step larger than the frequency
    send_cmd(fntc_pkg::OP_SET_FREQ, '0, '0, '0);
    run_random(40);

    // Zero reference with crossed limits: no frequency can be set
    set_limits(64'd0, 64'd2000000000, 64'd1000000000);
    run_random(30);

    // Neither side idles from here on
    snd_idle_pct = 0;
    rcv_idle_pct = 0;

    r_ref = rand_in(64'd1, 64'd250000000);
    r_lo  = rand_in(64'd0, TOP_HZ);
    r_hi  = rand_in(r_lo, TOP_HZ);
    set_limits(r_ref, r_lo, r_hi);
    run_random(50);

    set_limits(64'd10000000, 64'd35000000, TOP_HZ);
    run_random(60);

    // Drain, then allow a command's worth of cycles for any stray beat
    wait_idle();
    repeat (64) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_frac_n_synth_tuning_control_top passed");
    end else begin
      $display("tb_frac_n_synth_tuning_control_top failed");
    end
    $finish;
  end

endmodule
